>>> rtl/stbs_pkg.sv
package stbs_pkg;

  localparam int unsigned TYPE_W   = 8;
  localparam int unsigned RID_W    = 16;
  localparam int unsigned KEY_W    = TYPE_W + RID_W;
  localparam int unsigned FIELD_W  = 24;
  localparam int unsigned PAY_W    = 2 * FIELD_W;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned S_DATA_W = 72;
  localparam int unsigned M_DATA_W = 64;
  localparam int unsigned M_USER_W = 2;

  typedef enum logic {
    KIND_APPEND = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic hit;
    logic miss;
  } step_t;

endpackage

>>> rtl/stbs_table.sv
module stbs_table #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [stbs_pkg::KEY_W-1:0] wr_key_i,
  input  logic [stbs_pkg::PAY_W-1:0] wr_pay_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [stbs_pkg::KEY_W-1:0] rd_key_o,
  output logic [stbs_pkg::PAY_W-1:0] rd_pay_o
);

  logic [stbs_pkg::KEY_W-1:0] key_mem [DEPTH];
  logic [stbs_pkg::PAY_W-1:0] pay_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
      pay_mem[wr_addr_i] <= wr_pay_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_key_o <= key_mem[rd_addr_i];
    rd_pay_o <= pay_mem[rd_addr_i];
  end

endmodule

>>> rtl/stbs_step.sv
module stbs_step #(
  parameter int unsigned AW = 8,
  parameter int unsigned CW = 9
) (
  input  logic [CW-1:0]              lo_i,
  input  logic [CW-1:0]              hi_i,
  input  logic [AW-1:0]              mid_i,
  input  logic [stbs_pkg::KEY_W-1:0] key_i,
  input  logic [stbs_pkg::KEY_W-1:0] entry_key_i,
  output logic [CW-1:0]              lo_o,
  output logic [CW-1:0]              hi_o,
  output logic [AW-1:0]              mid_o,
  output stbs_pkg::step_t            step_o
);

  logic          below;
  logic [CW-1:0] mid_ext;
  logic [CW:0]   sum;

  // A single unsigned compare on {type, resource} orders type first.
  assign below   = key_i < entry_key_i;
  assign mid_ext = CW'(mid_i);
  assign lo_o    = below ? lo_i : mid_ext + CW'(1);
  assign hi_o    = below ? mid_ext : hi_i;
  assign sum     = {1'b0, lo_o} + {1'b0, hi_o};
  assign mid_o   = sum[AW:1];

  assign step_o.hit  = key_i == entry_key_i;
  assign step_o.miss = (key_i != entry_key_i) && (lo_o >= hi_o);

endmodule

>>> rtl/sorted_table_binary_search_top.sv
// Sorted resource table with binary-search lookup.
// Input stream: tuser carries the kind (append or lookup); tdata carries the
// key (type id, resource id) and, for an append, the payload offset and length.
// Output stream: one transfer per input transfer, with status and found in
// tuser and the position, entry offset and entry length in tdata.
// An append writes the entry in the accept cycle; the result then waits in the
// result registers and is loaded into the output register once that register
// is free or its result is being taken.
// A lookup makes one probe per cycle, at most ceil(log2(n + 1)) probes for n
// stored entries, so nine for a full table of 256. Each probe reads the key and
// payload memories at the midpoint and compares once; the compare result
// addresses the next probe directly.
// One item is in work at a time; the next input is accepted in the cycle after
// the previous result has moved to the output register, even while that result
// is stalled by the receiver. An append passes through IDLE and EMIT; a lookup
// adds SEARCH if entries are stored. A stalled result holds until it is taken.
// Reset empties the table; stored entries are not cleared.
module sorted_table_binary_search_top #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // type_id[7:0], resource_id[23:8], data_offset[47:24], data_length[71:48]
  input  logic [stbs_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  // kind[0]
  input  logic [0:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // position[8:0], entry_offset[32:9], entry_length[56:33], zero[63:57]
  output logic [stbs_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  // status[0], found[1]
  output logic [stbs_pkg::M_USER_W-1:0] m_axis_tuser_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned FW = stbs_pkg::FIELD_W;
  localparam int unsigned PW = stbs_pkg::POS_W;

  function automatic logic [PW-1:0] to_pos(input logic [CW-1:0] v);
    logic [PW+CW-1:0] wide;
    wide = {{PW{1'b0}}, v};
    return wide[PW-1:0];
  endfunction

  stbs_pkg::state_e state_q, state_d;

  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]              mid_q, mid_d;
  logic [stbs_pkg::KEY_W-1:0] key_q, key_d;

  logic          res_status_q, res_status_d;
  logic          res_found_q, res_found_d;
  logic [PW-1:0] res_pos_q, res_pos_d;
  logic [FW-1:0] res_off_q, res_off_d;
  logic [FW-1:0] res_len_q, res_len_d;

  logic          m_valid_q;
  logic          m_status_q, m_found_q;
  logic [PW-1:0] m_pos_q;
  logic [FW-1:0] m_off_q, m_len_q;
  logic          out_load;

  logic                       wr_en;
  logic [AW-1:0]              rd_addr;
  logic [stbs_pkg::KEY_W-1:0] in_key;
  logic [stbs_pkg::PAY_W-1:0] in_pay;
  logic [stbs_pkg::KEY_W-1:0] rd_key;
  logic [stbs_pkg::PAY_W-1:0] rd_pay;
  logic [CW-1:0]              half_count;

  logic [CW-1:0]   lo_n, hi_n;
  logic [AW-1:0]   mid_n;
  stbs_pkg::step_t step;

  assign in_key     = {s_axis_tdata_i[7:0], s_axis_tdata_i[23:8]};
  assign in_pay     = {s_axis_tdata_i[47:24], s_axis_tdata_i[71:48]};
  assign half_count = count_q >> 1;

  stbs_table #(
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(count_q[AW-1:0]),
    .wr_key_i (in_key),
    .wr_pay_i (in_pay),
    .rd_addr_i(rd_addr),
    .rd_key_o (rd_key),
    .rd_pay_o (rd_pay)
  );

  stbs_step #(
    .AW(AW),
    .CW(CW)
  ) u_step (
    .lo_i       (lo_q),
    .hi_i       (hi_q),
    .mid_i      (mid_q),
    .key_i      (key_q),
    .entry_key_i(rd_key),
    .lo_o       (lo_n),
    .hi_o       (hi_n),
    .mid_o      (mid_n),
    .step_o     (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stbs_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_pos_q    <= res_pos_d;
    res_off_q    <= res_off_d;
    res_len_q    <= res_len_d;
  end

  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    lo_d            = lo_q;
    hi_d            = hi_q;
    mid_d           = mid_q;
    key_d           = key_q;
    res_status_d    = res_status_q;
    res_found_d     = res_found_q;
    res_pos_d       = res_pos_q;
    res_off_d       = res_off_q;
    res_len_d       = res_len_q;
    wr_en           = 1'b0;
    rd_addr         = mid_q;
    s_axis_tready_o = 1'b0;
    out_load        = 1'b0;

    unique case (state_q)
      stbs_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          res_status_d = stbs_pkg::STATUS_OK;
          res_found_d  = 1'b0;
          res_pos_d    = to_pos(count_q);
          res_off_d    = '0;
          res_len_d    = '0;
          state_d      = stbs_pkg::ST_EMIT;
          if (s_axis_tuser_i[0] == stbs_pkg::KIND_LOOKUP) begin
            key_d   = in_key;
            lo_d    = '0;
            hi_d    = count_q;
            mid_d   = half_count[AW-1:0];
            rd_addr = half_count[AW-1:0];
            if (count_q == '0) begin
              res_pos_d = '0;
            end else begin
              state_d = stbs_pkg::ST_SEARCH;
            end
          end else if (count_q == CW'(TABLE_DEPTH)) begin
            res_status_d = stbs_pkg::STATUS_FULL;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
      end
      stbs_pkg::ST_SEARCH: begin
        if (step.hit) begin
          res_found_d = 1'b1;
          res_pos_d   = to_pos(CW'(mid_q));
          res_off_d   = rd_pay[2*FW-1:FW];
          res_len_d   = rd_pay[FW-1:0];
          state_d     = stbs_pkg::ST_EMIT;
        end else begin
          lo_d = lo_n;
          hi_d = hi_n;
          if (step.miss) begin
            res_pos_d = to_pos(lo_n);
            state_d   = stbs_pkg::ST_EMIT;
          end else begin
            mid_d   = mid_n;
            rd_addr = mid_n;
          end
        end
      end
      stbs_pkg::ST_EMIT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = stbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = stbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_status_q <= res_status_q;
      m_found_q  <= res_found_q;
      m_pos_q    <= res_pos_q;
      m_off_q    <= res_off_q;
      m_len_q    <= res_len_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(stbs_pkg::M_DATA_W - PW - 2 * FW){1'b0}},
                            m_len_q, m_off_q, m_pos_q};
  assign m_axis_tuser_o  = {m_found_q, m_status_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == stbs_pkg::ST_SEARCH |-> lo_q < hi_q)
    else $error("search window empty while probing");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> count_q == $past(count_q) + CW'(1))
    else $error("append did not advance entry count");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("refused append reported as found");

endmodule

>>> bench/tb_sorted_table_binary_search_top.sv
module tb_sorted_table_binary_search_top;

  localparam int unsigned DEPTH         = 256;
  localparam int unsigned RANDOM_ITEMS  = 1530;
  localparam int unsigned CALM_ITEMS    = 200;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES  = 20;

  typedef struct {
    stbs_pkg::status_e          status;
    logic                       found;
    logic [stbs_pkg::POS_W-1:0] position;
    logic [23:0]                offset;
    logic [23:0]                length;
  } answer_t;

  // Keeps its own copy of the resource table and predicts every answer.
  class resource_table_sb;
    logic [stbs_pkg::KEY_W-1:0] keys[DEPTH];
    logic [stbs_pkg::PAY_W-1:0] payloads[DEPTH];
    int unsigned                filled;
    answer_t                    awaited[$];
    int unsigned                errors;

    function void note_request(stbs_pkg::kind_e kind, logic [stbs_pkg::KEY_W-1:0] key,
                               logic [23:0] off, logic [23:0] len);
      answer_t     a;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      bit          hit;
      a.status   = stbs_pkg::STATUS_OK;
      a.found    = 1'b0;
      a.position = '0;
      a.offset   = '0;
      a.length   = '0;
      if (kind == stbs_pkg::KIND_APPEND) begin
        a.position = stbs_pkg::POS_W'(filled);
        if (filled >= DEPTH) begin
          a.status = stbs_pkg::STATUS_FULL;
        end else begin
          keys[filled]     = key;
          payloads[filled] = {off, len};
          filled++;
        end
      end else begin
        lo  = 0;
        hi  = filled;
        hit = 1'b0;
        mid = 0;
        while (lo < hi && !hit) begin
          mid = (lo + hi) >> 1;
          if (key < keys[mid]) begin
            hi = mid;
          end else if (key > keys[mid]) begin
            lo = mid + 1;
          end else begin
            hit = 1'b1;
          end
        end
        if (hit) begin
          a.found    = 1'b1;
          a.position = stbs_pkg::POS_W'(mid);
          a.offset   = payloads[mid][47:24];
          a.length   = payloads[mid][23:0];
        end else begin
          a.position = stbs_pkg::POS_W'(lo);
        end
      end
      awaited.push_back(a);
    endfunction

    function void compare_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_answer(logic [stbs_pkg::M_DATA_W-1:0] data,
                               logic [stbs_pkg::M_USER_W-1:0] user);
      answer_t want;
      if (awaited.size() == 0) begin
        $error("result transfer with no request outstanding: tdata %0h tuser %0h",
               data, user);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("status", 24'(want.status), 24'(user[0]));
      compare_field("found", 24'(want.found), 24'(user[1]));
      compare_field("position", 24'(want.position), 24'(data[8:0]));
      compare_field("entry_offset", want.offset, data[32:9]);
      compare_field("entry_length", want.length, data[56:33]);
    endfunction
  endclass

  logic                          clk_i  = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_valid = 1'b0;
  logic                          s_ready;
  logic [stbs_pkg::S_DATA_W-1:0] s_data = '0;
  logic [0:0]                    s_user = '0;
  logic                          m_valid;
  logic                          m_ready = 1'b0;
  logic [stbs_pkg::M_DATA_W-1:0] m_data;
  logic [stbs_pkg::M_USER_W-1:0] m_user;

  resource_table_sb           sb = new;
  bit                         calm = 1'b0;
  int unsigned                taken = 0;
  int unsigned                quiet = 0;
  logic [stbs_pkg::KEY_W-1:0] last_key;

  always #4 clk_i = ~clk_i;

  sorted_table_binary_search_top #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  // Called just after a falling edge; returns just after the falling edge that
  // follows the accepting rising edge.
  task automatic send_request(stbs_pkg::kind_e kind, logic [stbs_pkg::KEY_W-1:0] key,
                              logic [23:0] off, logic [23:0] len);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {len, off, key[15:0], key[23:16]};
    do @(posedge clk_i); while (!s_ready);
    sb.note_request(kind, key, off, len);
    @(negedge clk_i);
  endtask

  task automatic send_lookup(logic [stbs_pkg::KEY_W-1:0] key);
    send_request(stbs_pkg::KIND_LOOKUP, key, 24'($urandom), 24'($urandom));
  endtask

  initial begin : source
    stbs_pkg::kind_e            kind;
    logic [stbs_pkg::KEY_W-1:0] key;
    int unsigned                pick;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_lookup(24'h000000);
    send_lookup(24'hFFFFFF);
    send_request(stbs_pkg::KIND_APPEND, 24'h000000, 24'hFFFFFF, 24'h000000);
    send_request(stbs_pkg::KIND_APPEND, 24'h123456, 24'h000000, 24'hFFFFFF);
    send_lookup(24'h000000);
    send_lookup(24'h123456);
    send_lookup(24'h123455);
    send_lookup(24'h123457);
    send_lookup(24'h050000);
    send_lookup(24'hFFFFFF);
    send_request(stbs_pkg::KIND_APPEND, 24'h120000, 24'hA5A5A5, 24'h5A5A5A);
    send_lookup(24'h120000);
    send_lookup(24'h123456);
    send_lookup(24'h7FFFFF);
    last_key = 24'h123456;

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
      if (sb.filled < DEPTH) begin
        kind = ($urandom_range(0, 2) == 0) ? stbs_pkg::KIND_APPEND : stbs_pkg::KIND_LOOKUP;
      end else begin
        kind = ($urandom_range(0, 11) == 0) ? stbs_pkg::KIND_APPEND : stbs_pkg::KIND_LOOKUP;
      end
      if (kind == stbs_pkg::KIND_APPEND) begin
        if (sb.filled == DEPTH - 1) begin
          key = 24'hFFFFFF;
        end else if (sb.filled >= DEPTH || $urandom_range(0, 29) == 0) begin
          key = 24'($urandom);
        end else begin
          last_key = last_key + 24'($urandom_range(1, 50000));
          key = last_key;
        end
      end else begin
        pick = $urandom_range(0, 9);
        if (sb.filled > 0 && pick < 6) begin
          key = sb.keys[$urandom_range(0, sb.filled - 1)];
          if (pick >= 4) key = $urandom_range(0, 1) ? key + 24'd1 : key - 24'd1;
        end else begin
          key = 24'($urandom);
        end
      end
      send_request(kind, key, 24'($urandom), 24'($urandom));
    end
    s_valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("** sorted_table_binary_search_top: PASSED **");
    end else begin
      $display("** sorted_table_binary_search_top: FAILED **");
    end
    $finish;
  end

  initial begin : sink
    int unsigned hold_left;
    bit          long_hold_done;
    hold_left      = 0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_ready <= 1'b0;
        hold_left--;
      end else if (!calm && !long_hold_done && taken >= 400) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD - 1;
        m_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 5);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      sb.check_answer(m_data, m_user);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("** sorted_table_binary_search_top: FAILED **");
        $finish;
      end
    end
  end

endmodule
